FILE: sv/thermistor_adc_to_temperature_assert.svh
// Assertion macros shared by the thermistor linearizer modules.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_ASSERT_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TAT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TAT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/tat_pkg.sv
// Package of the thermistor linearizer: word types, codes, coefficients.
// Used by every module of the block; depends on nothing.
package tat_pkg;

   localparam int SampleW  = 12;
   localparam int ProbeW   = 2;
   localparam int UnitW    = 2;
   localparam int TempW    = 19;
   localparam int FaultW   = 2;
   localparam int PullupW  = 20;
   localparam int FullW    = 16;
   localparam int CsrIdxW  = 1;
   localparam int CsrDataW = 20;

   localparam int AvgCountDef = 100;
   localparam int AdcBitsDef  = 12;
   localparam int QueueDepth  = 2;

   localparam int TempMax = 200000;
   localparam int TempMin = -100000;

   localparam logic [FaultW-1:0] FAULT_OK   = 2'd0;
   localparam logic [FaultW-1:0] FAULT_ZERO = 2'd1;
   localparam logic [FaultW-1:0] FAULT_FULL = 2'd2;

   localparam logic [UnitW-1:0] UNIT_KELVIN     = 2'd0;
   localparam logic [UnitW-1:0] UNIT_CELSIUS    = 2'd1;
   localparam logic [UnitW-1:0] UNIT_FAHRENHEIT = 2'd2;

   localparam logic [CsrIdxW-1:0] CSR_PULLUP     = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_FULL_SCALE = 1'd1;

   localparam logic [PullupW-1:0] PullupReset = 20'd10000;
   localparam logic [FullW-1:0]   FullReset   = 16'd4095;

   // ln 2 in Q24.
   localparam logic [23:0] Ln2Q24 = 24'd11629080;

   typedef struct packed {
      logic [SampleW-1:0] adc_sample;
      logic [ProbeW-1:0]  probe_type;
      logic               smooth;
      logic [UnitW-1:0]   unit;
   } req_type;

   typedef struct packed {
      logic signed [TempW-1:0] temperature;
      logic [FaultW-1:0]       fault;
   } rsp_type;

   // One conversion handed from the front to the back.
   typedef struct packed {
      logic [SampleW-1:0] sample;
      logic               coef_set;
      logic [UnitW-1:0]   unit;
   } job_type;

   typedef struct packed {
      logic [PullupW-1:0] pullup_ohms;
      logic [FullW-1:0]   adc_full_scale;
   } cfg_type;

   typedef enum logic [4:0] {
      B_IDLE,
      B_CHECK,
      B_LOG_NORM,
      B_LOG_SQ,
      B_LOG_ACC,
      B_LN_HI,
      B_LN_LO,
      B_Y,
      B_SQ20,
      B_CUBE,
      B_BY_HI,
      B_BY_LO,
      B_CC_HI,
      B_CC_LO,
      B_DSUM,
      B_DIV_START,
      B_DIV,
      B_KSET,
      B_F5_HI,
      B_F5_MID,
      B_F5_LO,
      B_FFIN,
      B_ROUND,
      B_DONE
   } back_state_type;

   // Steinhart-Hart coefficients: A and B in Q40, C in Q48.
   function automatic logic signed [39:0] coef_a(input logic coef_set);
      return coef_set ? 40'sd504170100 : 40'sd253629086;
   endfunction

   function automatic logic [28:0] coef_b(input logic coef_set);
      return coef_set ? 29'd309479600 : 29'd260546807;
   endfunction

   function automatic logic signed [26:0] coef_c(input logic coef_set);
      return coef_set ? -27'sd27944836 : 27'sd35568346;
   endfunction

   function automatic logic [4:0] msb_index(input logic [19:0] x);
      logic [4:0] k;
      k = 5'd0;
      for (int i = 0; i < 20; i++) begin
         if (x[i]) k = 5'(i);
      end
      return k;
   endfunction

endpackage

FILE: sv/tat_queue.sv
// Two-word job queue between the front and the back of the linearizer.
// Depends on tat_pkg for the job word type and depth, and on the assertion header.
`include "thermistor_adc_to_temperature_assert.svh"

module tat_queue import tat_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_word,
   input  logic    pop,
   output job_type pop_word,
   output logic    not_empty,
   output logic    full
);

   localparam int CntW = $clog2(QueueDepth + 1);
   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

   job_type         slot_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
      return (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_word;
   end

   assign pop_word  = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CntW'(QueueDepth));

   `TAT_ASSERT_IMPL(a_no_overflow, clock, reset, push, count_ff != CntW'(QueueDepth), "job word pushed into a full queue")

endmodule

FILE: sv/tat_front.sv
// Front of the linearizer: takes request words, runs the smoothing sum
// and hands finished jobs to the queue. Depends on tat_pkg.
module tat_front import tat_pkg::*; #(
   parameter int AVG_COUNT = AvgCountDef,
   parameter int ADC_BITS  = AdcBitsDef
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   input  logic    q_full,
   output logic    push,
   output job_type push_word
);

   localparam int SumW  = $clog2(AVG_COUNT * (2 ** SampleW));
   localparam int CntW  = $clog2(AVG_COUNT + 1);
   localparam int RecK  = SumW + $clog2(AVG_COUNT);
   localparam int RecMW = RecK + 1;
   localparam int ProdW = SumW + RecMW;
   // Reciprocal of AVG_COUNT; exact floor for every sum below 2**SumW.
   localparam logic [RecMW-1:0] RecM =
      RecMW'(((64'd1 << RecK) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT));
   localparam logic [SampleW-1:0] SampleMask =
      (ADC_BITS >= SampleW) ? '1 : SampleW'((64'd1 << ADC_BITS) - 64'd1);

   logic [SumW-1:0]    sum_ff, sum_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic [SampleW-1:0] sample;
   logic [SumW-1:0]    sum_next;
   logic [ProdW-1:0]   avg_prod;
   logic               accept;
   logic               run_done;

   always_comb begin
      accept    = req_valid && !q_full;
      sample    = req_word.adc_sample & SampleMask;
      sum_next  = sum_ff + SumW'(sample);
      run_done  = (cnt_ff == CntW'(AVG_COUNT - 1));
      avg_prod  = ProdW'(sum_next) * ProdW'(RecM);
      push      = accept && (!req_word.smooth || run_done);
      push_word.sample   = req_word.smooth ? avg_prod[RecK +: SampleW] : sample;
      push_word.coef_set = req_word.probe_type[1];
      push_word.unit     = req_word.unit;
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      // A direct word leaves a running sum alone.
      if (accept && req_word.smooth) begin
         if (run_done) begin
            sum_in = '0;
            cnt_in = '0;
         end else begin
            sum_in = sum_next;
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
   end

   assign req_stall = q_full;

endmodule

FILE: sv/tat_back.sv
// Back of the linearizer: sequencer around one shared multiplier and one
// restoring divider that turns a job into a temperature. Depends on tat_pkg.
`include "thermistor_adc_to_temperature_assert.svh"

module tat_back import tat_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    q_not_empty,
   input  job_type q_word,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   localparam logic [41:0] DivInitRem  = 42'd3276800;   // (100 * 2**56) >> 41
   localparam logic [43:0] KClampQ     = 44'd1 << 40;
   localparam logic [5:0]  DivKSteps   = 6'd41;
   localparam logic signed [41:0] KelvinOffQ16 = 42'sd1790115840;
   localparam logic signed [45:0] FahrOffQ16   = 46'sd209715200;
   // Reciprocals of five: exact floors for 22-bit and 25-bit dividends.
   localparam logic [22:0] M5Hi = 23'd6710887;     // ceil(2**25 / 5)
   localparam logic [25:0] M5Lo = 26'd53687092;    // ceil(2**28 / 5)

   back_state_type state_ff, state_in;
   job_type              job_ff, job_in;
   logic [1:0]           sel_ff, sel_in;
   logic [4:0]           rnd_ff, rnd_in;
   logic [4:0]           k_ff, k_in;
   logic [31:0]          m_ff, m_in;
   logic [31:0]          frac_ff, frac_in;
   logic signed [39:0]   l2_ff, l2_in;
   logic signed [65:0]   prod_ff, prod_in;
   logic signed [65:0]   acc_ff, acc_in;
   logic signed [33:0]   y_ff, y_in;
   logic signed [37:0]   cube_ff, cube_in;
   logic signed [39:0]   d_ff, d_in;
   logic [41:0]          r_ff, r_in;
   logic [43:0]          n_ff, n_in;
   logic [43:0]          q_ff, q_in;
   logic [41:0]          dv_ff, dv_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic signed [45:0]   v_ff, v_in;
   logic signed [TempW-1:0] temp_ff, temp_in;
   logic [FaultW-1:0]    fault_ff, fault_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_word_ff, rsp_word_in;

   logic signed [32:0]   mul_a, mul_b;
   logic signed [65:0]   mul_p;
   logic [19:0]          log_x;
   logic [4:0]           norm_k;
   logic [32:0]          sq_t;
   logic signed [65:0]   lnsum;
   logic [41:0]          r2;
   logic                 ge;
   logic [41:0]          d_mag;
   logic [40:0]          kmag;
   logic signed [41:0]   kq;
   logic signed [41:0]   cel;
   logic signed [44:0]   c9;
   logic [43:0]          c9_mag;
   logic signed [45:0]   fq;
   logic signed [45:0]   vr;
   logic signed [29:0]   rnd;
   logic signed [25:0]   y20;
   logic [44:0]          f5_hp;
   logic [21:0]          f5_rem;
   logic [50:0]          f5_lp;
   logic                 out_free;

   assign mul_p = mul_a * mul_b;

   always_comb begin
      log_x = (cfg.pullup_ohms == '0) ? 20'd1 : cfg.pullup_ohms;
      if (sel_ff == 2'd1) log_x = 20'(job_ff.sample);
      else if (sel_ff == 2'd2) log_x = 20'(cfg.adc_full_scale - 16'(job_ff.sample));
      norm_k = msb_index(log_x);
      sq_t   = mul_p[63:31];
      lnsum  = acc_ff + prod_ff;
      y20    = $signed(y_ff[33:8]);
      r2     = {r_ff[40:0], n_ff[43]};
      ge     = (r2 >= dv_ff);
      d_mag  = d_ff[39] ? 42'(-d_ff) : 42'(d_ff);
      kmag   = (q_ff[40:0] > KClampQ[40:0]) ? KClampQ[40:0] : q_ff[40:0];
      kq     = neg_ff ? -$signed({1'b0, kmag}) : $signed({1'b0, kmag});
      cel    = kq - KelvinOffQ16;
      c9     = (45'(cel) <<< 3) + 45'(cel);
      c9_mag = c9[44] ? 44'(-c9) : 44'(c9);
      fq     = (neg_ff ? -$signed({2'b00, q_ff}) : $signed({2'b00, q_ff})) + FahrOffQ16;
      vr     = v_ff + 46'sd32768;
      rnd    = $signed(vr[45:16]);
      // Division by five in two 22-bit digits: upper digit, its remainder, lower digit.
      f5_hp  = 45'(n_ff[43:22]) * 45'(M5Hi);
      f5_rem = n_ff[43:22] - ((q_ff[43:22] << 2) + q_ff[43:22]);
      f5_lp  = 51'(r_ff[24:0]) * 51'(M5Lo);
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   // Operand selection of the shared multiplier; wide products go as two halves.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         B_LOG_SQ: begin
            mul_a = $signed({1'b0, m_ff});
            mul_b = $signed({1'b0, m_ff});
         end
         B_LN_HI: begin
            mul_a = 33'($signed(l2_ff[39:16]));
            mul_b = $signed({9'd0, Ln2Q24});
         end
         B_LN_LO: begin
            mul_a = $signed({17'd0, l2_ff[15:0]});
            mul_b = $signed({9'd0, Ln2Q24});
         end
         B_SQ20: begin
            mul_a = 33'(y20);
            mul_b = 33'(y20);
         end
         B_CUBE: begin
            mul_a = $signed({1'b0, prod_ff[51:20]});
            mul_b = 33'(y20);
         end
         B_BY_HI: begin
            mul_a = 33'($signed(y_ff[33:16]));
            mul_b = $signed({4'd0, coef_b(job_ff.coef_set)});
         end
         B_BY_LO: begin
            mul_a = $signed({17'd0, y_ff[15:0]});
            mul_b = $signed({4'd0, coef_b(job_ff.coef_set)});
         end
         B_CC_HI: begin
            mul_a = 33'($signed(cube_ff[37:16]));
            mul_b = 33'(coef_c(job_ff.coef_set));
         end
         B_CC_LO: begin
            mul_a = $signed({17'd0, cube_ff[15:0]});
            mul_b = 33'(coef_c(job_ff.coef_set));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      sel_in   = sel_ff;
      rnd_in   = rnd_ff;
      k_in     = k_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      l2_in    = l2_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      y_in     = y_ff;
      cube_in  = cube_ff;
      d_in     = d_ff;
      r_in     = r_ff;
      n_in     = n_ff;
      q_in     = q_ff;
      dv_in    = dv_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      v_in     = v_ff;
      temp_in  = temp_ff;
      fault_in = fault_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pop      = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (q_not_empty) begin
               pop      = 1'b1;
               job_in   = q_word;
               state_in = B_CHECK;
            end
         end
         B_CHECK: begin
            l2_in    = '0;
            sel_in   = 2'd0;
            temp_in  = '0;
            fault_in = FAULT_OK;
            if (job_ff.sample == '0) begin
               fault_in = FAULT_ZERO;
               state_in = B_DONE;
            end else if (16'(job_ff.sample) >= cfg.adc_full_scale) begin
               fault_in = FAULT_FULL;
               state_in = B_DONE;
            end else begin
               state_in = B_LOG_NORM;
            end
         end
         B_LOG_NORM: begin
            k_in     = norm_k;
            m_in     = 32'(log_x) << (5'd31 - norm_k);
            frac_in  = '0;
            rnd_in   = '0;
            state_in = B_LOG_SQ;
         end
         B_LOG_SQ: begin
            // One fraction bit per squaring of the Q31 mantissa.
            frac_in = {frac_ff[30:0], sq_t[32]};
            m_in    = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
            rnd_in  = rnd_ff + 1'b1;
            if (rnd_ff == 5'd31) state_in = B_LOG_ACC;
         end
         B_LOG_ACC: begin
            sel_in = sel_ff + 1'b1;
            if (sel_ff == 2'd2) begin
               l2_in    = l2_ff - $signed(40'({k_ff, frac_ff}));
               state_in = B_LN_HI;
            end else begin
               l2_in    = l2_ff + $signed(40'({k_ff, frac_ff}));
               state_in = B_LOG_NORM;
            end
         end
         B_LN_HI: begin
            prod_in  = mul_p;
            state_in = B_LN_LO;
         end
         B_LN_LO: begin
            acc_in   = prod_ff <<< 16;
            prod_in  = mul_p;
            state_in = B_Y;
         end
         B_Y: begin
            y_in     = $signed(lnsum[61:28]);
            state_in = B_SQ20;
         end
         B_SQ20: begin
            prod_in  = mul_p;
            state_in = B_CUBE;
         end
         B_CUBE: begin
            prod_in  = mul_p;
            state_in = B_BY_HI;
         end
         B_BY_HI: begin
            cube_in  = $signed(prod_ff[57:20]);
            prod_in  = mul_p;
            state_in = B_BY_LO;
         end
         B_BY_LO: begin
            acc_in   = prod_ff <<< 16;
            prod_in  = mul_p;
            state_in = B_CC_HI;
         end
         B_CC_HI: begin
            d_in     = coef_a(job_ff.coef_set) + 40'($signed(lnsum[65:28]));
            prod_in  = mul_p;
            state_in = B_CC_LO;
         end
         B_CC_LO: begin
            acc_in   = prod_ff <<< 16;
            prod_in  = mul_p;
            state_in = B_DSUM;
         end
         B_DSUM: begin
            d_in     = d_ff + 40'($signed(lnsum[65:28]));
            state_in = B_DIV_START;
         end
         B_DIV_START: begin
            if (d_ff == '0) begin
               temp_in  = TempW'(TempMax);
               state_in = B_DONE;
            end else begin
               neg_in  = d_ff[39];
               dv_in   = d_mag;
               r_in    = DivInitRem;
               n_in    = '0;
               q_in    = '0;
               cnt_in  = DivKSteps;
               // A quotient of 2**41 or more is clamped without dividing.
               if (DivInitRem >= d_mag) begin
                  q_in     = KClampQ;
                  state_in = B_KSET;
               end else begin
                  state_in = B_DIV;
               end
            end
         end
         B_DIV: begin
            r_in   = ge ? (r2 - dv_ff) : r2;
            q_in   = {q_ff[42:0], ge};
            n_in   = {n_ff[42:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == 6'd1) state_in = B_KSET;
         end
         B_KSET: begin
            unique case (job_ff.unit)
               UNIT_CELSIUS: begin
                  v_in     = 46'(cel);
                  state_in = B_ROUND;
               end
               UNIT_FAHRENHEIT: begin
                  neg_in   = c9[44];
                  n_in     = c9_mag;
                  q_in     = '0;
                  state_in = B_F5_HI;
               end
               default: begin
                  v_in     = 46'(kq);
                  state_in = B_ROUND;
               end
            endcase
         end
         B_F5_HI: begin
            q_in     = {2'b00, f5_hp[44:25], 22'd0};
            state_in = B_F5_MID;
         end
         B_F5_MID: begin
            r_in     = 42'({f5_rem[2:0], n_ff[21:0]});
            state_in = B_F5_LO;
         end
         B_F5_LO: begin
            q_in     = {q_ff[43:22], f5_lp[49:28]};
            state_in = B_FFIN;
         end
         B_FFIN: begin
            v_in     = fq;
            state_in = B_ROUND;
         end
         B_ROUND: begin
            if (rnd > 30'(TempMax)) temp_in = TempW'(TempMax);
            else if (rnd < 30'(TempMin)) temp_in = TempW'(TempMin);
            else temp_in = TempW'(rnd);
            state_in = B_DONE;
         end
         B_DONE: begin
            if (out_free) begin
               rsp_word_in.temperature = temp_ff;
               rsp_word_in.fault       = fault_ff;
               rsp_valid_in = 1'b1;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      sel_ff      <= sel_in;
      rnd_ff      <= rnd_in;
      k_ff        <= k_in;
      m_ff        <= m_in;
      frac_ff     <= frac_in;
      l2_ff       <= l2_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      y_ff        <= y_in;
      cube_ff     <= cube_in;
      d_ff        <= d_in;
      r_ff        <= r_in;
      n_ff        <= n_in;
      q_ff        <= q_in;
      dv_ff       <= dv_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      v_ff        <= v_in;
      temp_ff     <= temp_in;
      fault_ff    <= fault_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `TAT_ASSERT_IMPL(a_fault_zero_temp, clock, reset, rsp_valid_ff && rsp_word_ff.fault != FAULT_OK, rsp_word_ff.temperature == '0, "faulted word carries a nonzero temperature")
   `TAT_ASSERT_IMPL(a_temp_range, clock, reset, rsp_valid_ff, rsp_word_ff.temperature >= TempW'(TempMin) && rsp_word_ff.temperature <= TempW'(TempMax), "temperature outside the saturation range")
   `TAT_ASSERT_IMPL(a_div_nonzero, clock, reset, state_ff == B_DIV, dv_ff != '0, "divider running with a zero divisor")
   `TAT_ASSERT_NEXT(a_done_loads, clock, reset, state_ff == B_DONE && out_free, rsp_valid_ff && state_ff == B_IDLE, "finished job did not reach the output register")

endmodule

FILE: sv/thermistor_adc_to_temperature.sv
// Thermistor linearizer top level: request, result and register channels.
// Request words (sample, probe set, smoothing, unit) are taken when req_valid
// is high and req_stall low; result words (temperature in hundredths of a
// degree, fault) leave the same way on rsp_. The csr_ port writes the pull-up
// resistance (index 0) and the converter full scale (index 1); csr_ready is
// always high. A smoothed word gives a result only when it completes a run.
// The front takes a word a cycle while the two-word job queue has room. The
// back handles one job at a time: a faulted job skips the conversion, a Kelvin or
// Celsius conversion runs three 32-round log2 evaluations on the shared
// multiplier and a 41-step restoring division, and Fahrenheit adds
// a division by five in three reciprocal steps and a final offset; a
// clamped quotient saves the 41 steps.
// The back takes no new job until its last result has been loaded.
// Reset is synchronous: it empties the queue, clears the smoothing run and
// the result valid flag, and restores the register defaults.
// While rsp_stall is high the result word holds; the back waits with its
// next result and the front keeps filling the queue until it is full.
// Depends on tat_pkg, tat_front, tat_queue and tat_back.
module thermistor_adc_to_temperature import tat_pkg::*; #(
   parameter int AVG_COUNT = AvgCountDef,
   parameter int ADC_BITS  = AdcBitsDef
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_word,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_word,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   logic [PullupW-1:0] pullup_ff, pullup_in;
   logic [FullW-1:0]   full_ff, full_in;
   cfg_type            cfg;
   logic               push, pop, q_full, q_not_empty;
   job_type            push_word, pop_word;

   always_comb begin
      pullup_in = pullup_ff;
      full_in   = full_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PULLUP:     pullup_in = csr_wdata[PullupW-1:0];
            CSR_FULL_SCALE: full_in   = csr_wdata[FullW-1:0];
            default:        pullup_in = pullup_ff;
         endcase
      end
      cfg.pullup_ohms    = pullup_ff;
      cfg.adc_full_scale = full_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pullup_ff <= PullupReset;
         full_ff   <= FullReset;
      end else begin
         pullup_ff <= pullup_in;
         full_ff   <= full_in;
      end
   end

   assign csr_ready = 1'b1;

   tat_front #(
      .AVG_COUNT (AVG_COUNT),
      .ADC_BITS  (ADC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .q_full    (q_full),
      .push      (push),
      .push_word (push_word)
   );

   tat_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .pop_word  (pop_word),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   tat_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .q_not_empty (q_not_empty),
      .q_word      (pop_word),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench of the thermistor linearizer (thermistor_adc_to_temperature).
// Depends on tat_pkg and the block; a built-in predictor checks every result word.
`timescale 1ns / 1ps

module tb_top;
   import tat_pkg::*;

   localparam int NumPhases    = 6;
   localparam int WordsPerPhase = 300;
   localparam int SettleCycles = 300;
   localparam int HoldCycles   = 3000;
   localparam longint CycleLimit = 4000000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   req_type             req_word;
   logic                rsp_valid;
   logic                rsp_stall;
   rsp_type             rsp_word;
   logic                csr_valid;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   thermistor_adc_to_temperature DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   typedef struct packed {
      logic [SampleW-1:0] sample;
      logic [ProbeW-1:0]  probe;
      logic               smooth;
      logic [UnitW-1:0]   unit;
      logic               typed;
      logic [TempW-1:0]   temp;
      logic [FaultW-1:0]  fault;
   } row_type;

   localparam int NumRows = 20;
   localparam row_type DirTab [NumRows] = '{
      '{12'd0,    2'd0, 1'b0, UNIT_KELVIN,     1'b1, 19'd0, FAULT_ZERO},
      '{12'd0,    2'd2, 1'b0, UNIT_FAHRENHEIT, 1'b1, 19'd0, FAULT_ZERO},
      '{12'd4095, 2'd0, 1'b0, UNIT_CELSIUS,    1'b1, 19'd0, FAULT_FULL},
      '{12'd4095, 2'd2, 1'b0, UNIT_KELVIN,     1'b1, 19'd0, FAULT_FULL},
      '{12'd4094, 2'd0, 1'b0, UNIT_KELVIN,     1'b0, 19'd0, FAULT_OK},
      '{12'd4094, 2'd2, 1'b0, UNIT_FAHRENHEIT, 1'b0, 19'd0, FAULT_OK},
      '{12'd1,    2'd0, 1'b0, UNIT_KELVIN,     1'b0, 19'd0, FAULT_OK},
      '{12'd1,    2'd2, 1'b0, UNIT_CELSIUS,    1'b0, 19'd0, FAULT_OK},
      '{12'd2048, 2'd0, 1'b0, UNIT_CELSIUS,    1'b0, 19'd0, FAULT_OK},
      '{12'd2048, 2'd1, 1'b0, UNIT_CELSIUS,    1'b0, 19'd0, FAULT_OK},
      '{12'd2048, 2'd2, 1'b0, UNIT_CELSIUS,    1'b0, 19'd0, FAULT_OK},
      '{12'd2048, 2'd3, 1'b0, UNIT_CELSIUS,    1'b0, 19'd0, FAULT_OK},
      '{12'd2048, 2'd1, 1'b0, UNIT_KELVIN,     1'b0, 19'd0, FAULT_OK},
      '{12'd2048, 2'd1, 1'b0, UNIT_FAHRENHEIT, 1'b0, 19'd0, FAULT_OK},
      '{12'd2048, 2'd1, 1'b0, 2'd3,            1'b0, 19'd0, FAULT_OK},
      '{12'd1000, 2'd2, 1'b0, 2'd3,            1'b0, 19'd0, FAULT_OK},
      '{12'd3000, 2'd3, 1'b0, UNIT_FAHRENHEIT, 1'b0, 19'd0, FAULT_OK},
      '{12'd2730, 2'd0, 1'b0, UNIT_FAHRENHEIT, 1'b0, 19'd0, FAULT_OK},
      '{12'd1365, 2'd2, 1'b0, UNIT_KELVIN,     1'b0, 19'd0, FAULT_OK},
      '{12'd5,    2'd1, 1'b0, UNIT_FAHRENHEIT, 1'b0, 19'd0, FAULT_OK}
   };

   // Register settings per random phase; zero values exercise the special cases.
   localparam logic [PullupW-1:0] PhasePullup [NumPhases] =
      '{20'd10000, 20'd1, 20'hFFFFF, 20'd0, 20'd4700, 20'd1000000};
   localparam logic [FullW-1:0] PhaseFull [NumPhases] =
      '{16'd4095, 16'd65535, 16'd1, 16'd0, 16'd2048, 16'd3000};

   rsp_type     temp_expect_q[$];
   int unsigned pull_ohms;
   int unsigned full_scale;
   int unsigned run_sum;
   int unsigned run_count;
   int          send_idle;
   int          recv_idle;
   bit          hold_req;
   bit          hold_done;
   int          hold_left;
   int          errors;
   int          mismatches;
   longint      cycles;

   function automatic longint unsigned log2_q32(input int unsigned x);
      int unsigned k;
      longint unsigned m;
      longint unsigned frac;
      k = 0;
      frac = 0;
      if (x == 0) x = 1;
      while (k < 31 && (x >> (k + 1)) != 0) k++;
      m = longint'(x) << (31 - k);
      for (int i = 0; i < 32; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= (64'd1 << 32)) begin
            m = m >> 1;
            frac = frac | 64'd1;
         end
      end
      return (longint'(k) << 32) | frac;
   endfunction

   function automatic rsp_type linearize(input int unsigned s, input logic [1:0] probe,
                                         input logic [1:0] unit);
      rsp_type r;
      int unsigned pur;
      longint l2, y, y20, cube, d, kq, v, ca, cb, cc;
      pur = (pull_ohms != 0) ? pull_ohms : 1;
      r.temperature = '0;
      if (s == 0) begin
         r.fault = FAULT_ZERO;
         return r;
      end
      if (s >= full_scale) begin
         r.fault = FAULT_FULL;
         return r;
      end
      r.fault = FAULT_OK;
      if (probe < 2) begin
         ca = 253629086; cb = 260546807; cc = 35568346;
      end else begin
         ca = 504170100; cb = 309479600; cc = -27944836;
      end
      l2 = longint'(log2_q32(pur)) + longint'(log2_q32(s))
           - longint'(log2_q32(full_scale - s));
      y = (l2 * 64'sd11629080) >>> 28;
      y20 = y >>> 8;
      cube = (((y20 * y20) >>> 20) * y20) >>> 20;
      d = ca + ((cb * y) >>> 28) + ((cc * cube) >>> 28);
      if (d == 0) begin
         r.temperature = TempMax;
         return r;
      end
      kq = (64'sd100 * (64'sd1 <<< 56)) / d;
      if (kq > (64'sd1 <<< 40)) kq = 64'sd1 <<< 40;
      if (kq < -(64'sd1 <<< 40)) kq = -(64'sd1 <<< 40);
      if (unit == UNIT_CELSIUS)
         v = kq - 64'sd27315 * 65536;
      else if (unit == UNIT_FAHRENHEIT)
         v = ((kq - 64'sd27315 * 65536) * 9) / 5 + 64'sd3200 * 65536;
      else
         v = kq;
      v = (v + 32768) >>> 16;
      if (v > TempMax) v = TempMax;
      if (v < TempMin) v = TempMin;
      r.temperature = v[TempW-1:0];
      return r;
   endfunction

   // Updates the smoothing run and queues the expected word, if the word makes one.
   function automatic void predict_temp(input req_type w);
      int unsigned s;
      s = w.adc_sample;
      if (w.smooth) begin
         run_sum += s;
         run_count++;
         if (run_count < AvgCountDef) return;
         s = run_sum / AvgCountDef;
         run_sum = 0;
         run_count = 0;
      end
      temp_expect_q.push_back(linearize(s, w.probe_type, w.unit));
   endfunction

   task automatic send_word(input req_type w);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
   endtask

   // Leaves csr_valid high; the caller drops it after its last write.
   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_PULLUP) pull_ohms = data;
      else full_scale = data[FullW-1:0];
   endtask

   task automatic drain();
      while (temp_expect_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic req_type random_word(input int smooth_pct);
      req_type w;
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: w.adc_sample = '0;
         1: w.adc_sample = '1;
         2: w.adc_sample = 12'd1;
         3: w.adc_sample = 12'(full_scale - 1);
         4: w.adc_sample = 12'(full_scale);
         default: w.adc_sample = 12'($urandom_range(0, 4095));
      endcase
      w.probe_type = 2'($urandom_range(0, 3));
      w.unit = 2'($urandom_range(0, 3));
      w.smooth = ($urandom_range(0, 99) < smooth_pct);
      return w;
   endfunction

   initial begin
      clock = 1'b0;
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: random stall, one long hold-off on request, and the checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (temp_expect_q.size() == 0) begin
            errors++;
            if (mismatches < 10) $display("Unexpected result word %h", rsp_word);
            mismatches++;
         end else begin
            rsp_type want;
            want = temp_expect_q.pop_front();
            if (want.temperature !== rsp_word.temperature || want.fault !== rsp_word.fault) begin
               errors++;
               if (mismatches < 10)
                  $display("Mismatch: expected temp %0d fault %0d, got temp %0d fault %0d",
                           want.temperature, want.fault,
                           rsp_word.temperature, rsp_word.fault);
               mismatches++;
            end
         end
      end
      if (hold_req && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HoldCycles;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle);
      end
   end

   initial begin
      req_type w;
      cycles = 0;
      errors = 0;
      mismatches = 0;
      hold_req = 0;
      hold_done = 0;
      hold_left = 0;
      send_idle = 38;
      recv_idle = 45;
      pull_ohms = PullupReset;
      full_scale = FullReset;
      run_sum = 0;
      run_count = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words against the reset register values.
      for (int i = 0; i < NumRows; i++) begin
         w.adc_sample = DirTab[i].sample;
         w.probe_type = DirTab[i].probe;
         w.smooth = DirTab[i].smooth;
         w.unit = DirTab[i].unit;
         send_word(w);
         if (DirTab[i].typed)
            temp_expect_q.push_back('{temperature: DirTab[i].temp, fault: DirTab[i].fault});
         else
            predict_temp(w);
      end
      req_valid <= 1'b0;

      for (int p = 0; p < NumPhases; p++) begin
         if (p < 2) begin
            send_idle = 38; recv_idle = 45;
         end else if (p < 4) begin
            send_idle = 45; recv_idle = 38;
         end else begin
            send_idle = 0; recv_idle = 0;
         end
         drain();
         write_reg(CSR_PULLUP, PhasePullup[p]);
         write_reg(CSR_FULL_SCALE, CsrDataW'(PhaseFull[p]));
         csr_valid <= 1'b0;
         if (p == NumPhases - 1) hold_req = 1'b1;
         // Mostly smoothed words, with stretches of mostly direct ones; smoothed runs complete now and then.
         for (int n = 0; n < WordsPerPhase; n++) begin
            w = random_word((n % 150) < 110 ? 90 : 5);
            send_word(w);
            predict_temp(w);
         end
         req_valid <= 1'b0;
      end

      drain();
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
